FILE: hdl/rtmp_chunk_encoder_macros.svh
// assertion macros used by the port-level checker file
`ifndef RTMP_CHUNK_ENCODER_MACROS_SVH
`define RTMP_CHUNK_ENCODER_MACROS_SVH

// implication checked every clock outside reset
`define RCE_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication with the consequent checked on the following clock
`define RCE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/rce_pkg.sv
// package with types, constants and helpers for the chunk encoder
package rce_pkg;

    localparam int STREAM_SLOTS = 1024;
    localparam int SLOT_W = $clog2(STREAM_SLOTS);
    localparam int CSID_W = 10;
    localparam logic [23:0] EXT_MARK = 24'hFFFFFF;
    localparam logic [23:0] CHUNK_MAX_RESET = 24'd128;
    localparam logic        CMD_HEADER = 1'b0;
    localparam logic        CMD_PAYLOAD = 1'b1;
    localparam int BUF_BYTES = 18;
    localparam int BUF_CNT_W = 5;

    typedef struct packed {
        logic              command;
        logic [CSID_W-1:0] csid;
        logic [31:0]       msg_stream;
        logic [7:0]        msg_type;
        logic [31:0]       timestamp;
        logic [23:0]       msg_len;
        logic [7:0]        payload_byte;
    } rce_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } rce_out_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] ts;
        logic [31:0] delta;
        logic [23:0] len;
        logic [7:0]  mtype;
        logic [31:0] stream;
        logic        ext_active;
        logic [31:0] ext_value;
    } slot_entry_t;

    localparam int SLOT_ENTRY_W = $bits(slot_entry_t);

    typedef logic [BUF_BYTES*8-1:0] byte_buf_t;

endpackage

FILE: hdl/rce_ram.sv
// generic single-port-write, single-port-read ram with registered read
module rce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hdl/rtmp_chunk_encoder.sv
// rtmp chunk stream encoder top level
//   channel  dir  handshake            payload
//   s_       in   s_valid / s_ready    rce_in_t
//   m_       out  m_valid / m_ready    rce_out_t
//   cfg      in   cfg_we               chunk length limit (24 bit)
// a plain payload item emits one byte, so payload bytes stream back to back;
// one that crosses a chunk boundary emits a run of 2 to 8 bytes.
// a header item first reads its slot memory entry, then emits its 1 to 18 byte run
// one byte per unstalled cycle; the next item is taken as the last byte leaves.
// after reset, a clearing pass zeroes all STREAM_SLOTS entries and holds s_ready low.
// reset is synchronous, active low; a stalled output holds s_ready low.
module rtmp_chunk_encoder
    import rce_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  rce_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output rce_out_t    m_data,
    input  logic        cfg_we,
    input  logic [23:0] cfg_data
);

    logic [23:0]       chunk_max_reg;
    logic [SLOT_W:0]   clr_cnt_reg;
    logic              clearing;

    logic              lk_reg;
    rce_in_t           hdr_reg;
    slot_entry_t       rd_entry;
    logic              fwd_valid_reg;
    slot_entry_t       fwd_entry_reg;
    logic [SLOT_W-1:0] fwd_addr_reg;
    slot_entry_t       cur_entry;

    byte_buf_t         buf_reg, buf_next;
    logic [BUF_CNT_W-1:0] cnt_reg, cnt_next;

    logic [9:0]        cur_slot_reg;
    logic [23:0]       msg_left_reg;
    logic [23:0]       chunk_left_reg;
    logic              cur_ext_reg;
    logic [31:0]       cur_extv_reg;

    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    slot_entry_t       mem_wdata;
    logic [SLOT_W-1:0] slot_idx;

    logic              out_free;
    logic              take;

    assign clearing = !clr_cnt_reg[SLOT_W];
    assign slot_idx = s_data.csid[SLOT_W-1:0];
    assign out_free = !m_valid || m_ready;
    assign s_ready  = !clearing && !lk_reg && (cnt_reg <= 5'd1) && out_free;
    assign take     = s_valid && s_ready;

    rce_ram #(.WIDTH(SLOT_ENTRY_W), .DEPTH(STREAM_SLOTS)) u_slots (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(slot_idx),
        .rdata(rd_entry)
    );

    always_comb begin
        cur_entry = rd_entry;
        if (fwd_valid_reg && fwd_addr_reg == hdr_reg.csid[SLOT_W-1:0]) begin
            cur_entry = fwd_entry_reg;
        end
    end

    // header decode
    logic [1:0]  fmt;
    logic [31:0] delta;
    logic        ext;
    logic [31:0] extv;
    logic [23:0] f24;
    slot_entry_t new_entry;
    logic [9:0]  csr;
    byte_buf_t   hb;
    logic [BUF_CNT_W-1:0] hn;

    always_comb begin
        delta = hdr_reg.timestamp - cur_entry.ts;
        if (!cur_entry.valid || hdr_reg.msg_stream != cur_entry.stream
            || hdr_reg.timestamp < cur_entry.ts) begin
            fmt = 2'd0;
        end else if (hdr_reg.msg_len != cur_entry.len
                     || hdr_reg.msg_type != cur_entry.mtype) begin
            fmt = 2'd1;
        end else if (delta != cur_entry.delta) begin
            fmt = 2'd2;
        end else begin
            fmt = 2'd3;
        end
        if (fmt == 2'd0) begin
            ext  = hdr_reg.timestamp >= {8'd0, EXT_MARK};
            extv = hdr_reg.timestamp;
        end else if (fmt != 2'd3) begin
            ext  = delta >= {8'd0, EXT_MARK};
            extv = delta;
        end else begin
            ext  = cur_entry.ext_active;
            extv = cur_entry.ext_value;
        end
        f24 = ext ? EXT_MARK : extv[23:0];

        hb = '0;
        hn = '0;
        csr = hdr_reg.csid - 10'd64;
        // bytes are packed from the top of the buffer downward
        if (hdr_reg.csid < 10'd64) begin
            hb = {fmt, hdr_reg.csid[5:0], 136'd0};
            hn = 5'd1;
        end else if (hdr_reg.csid < 10'd320) begin
            hb = {fmt, 6'd0, csr[7:0], 128'd0};
            hn = 5'd2;
        end else begin
            hb = {fmt, 6'd1, csr[7:0], 6'd0, csr[9:8], 120'd0};
            hn = 5'd3;
        end
        if (fmt == 2'd0) begin
            hb = hb | (byte_buf_t'({f24, hdr_reg.msg_len, hdr_reg.msg_type,
                       hdr_reg.msg_stream[7:0], hdr_reg.msg_stream[15:8],
                       hdr_reg.msg_stream[23:16], hdr_reg.msg_stream[31:24],
                       56'd0}) >> (hn * 8));
            hn = hn + 5'd11;
        end else if (fmt == 2'd1) begin
            hb = hb | (byte_buf_t'({f24, hdr_reg.msg_len, hdr_reg.msg_type,
                       88'd0}) >> (hn * 8));
            hn = hn + 5'd7;
        end else if (fmt == 2'd2) begin
            hb = hb | (byte_buf_t'({f24, 120'd0}) >> (hn * 8));
            hn = hn + 5'd3;
        end
        if (ext) begin
            hb = hb | (byte_buf_t'({extv, 112'd0}) >> (hn * 8));
            hn = hn + 5'd4;
        end

        new_entry.valid      = 1'b1;
        new_entry.ts         = hdr_reg.timestamp;
        new_entry.delta      = (fmt == 2'd0) ? 32'd0 : delta;
        new_entry.len        = hdr_reg.msg_len;
        new_entry.mtype      = hdr_reg.msg_type;
        new_entry.stream     = hdr_reg.msg_stream;
        new_entry.ext_active = ext;
        new_entry.ext_value  = extv;

        mem_we    = clearing || lk_reg;
        mem_waddr = clearing ? clr_cnt_reg[SLOT_W-1:0] : hdr_reg.csid[SLOT_W-1:0];
        mem_wdata = clearing ? slot_entry_t'('0) : new_entry;
    end

    // boundary insert for payload
    byte_buf_t pb;
    logic [BUF_CNT_W-1:0] pn;
    logic [9:0] cr;
    always_comb begin
        cr = cur_slot_reg - 10'd64;
        if (cur_slot_reg < 10'd64) begin
            pb = {2'd3, cur_slot_reg[5:0], 136'd0};
            pn = 5'd1;
        end else if (cur_slot_reg < 10'd320) begin
            pb = {2'd3, 6'd0, cr[7:0], 128'd0};
            pn = 5'd2;
        end else begin
            pb = {2'd3, 6'd1, cr[7:0], 6'd0, cr[9:8], 120'd0};
            pn = 5'd3;
        end
        if (cur_ext_reg) begin
            pb = pb | (byte_buf_t'({cur_extv_reg, 112'd0}) >> (pn * 8));
            pn = pn + 5'd4;
        end
        if (chunk_left_reg != 24'd0) begin
            pb = '0;
            pn = '0;
        end
        pb = pb | (byte_buf_t'({s_data.payload_byte, 136'd0}) >> (pn * 8));
        pn = pn + 5'd1;
    end

    always_comb begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (cnt_reg != '0 && out_free) begin
            buf_next = buf_reg << 8;
            cnt_next = cnt_reg - 5'd1;
        end
        if (lk_reg) begin
            buf_next = hb;
            cnt_next = hn;
        end else if (take && s_data.command == CMD_PAYLOAD && msg_left_reg != 24'd0) begin
            buf_next = pb;
            cnt_next = pn;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_max_reg  <= CHUNK_MAX_RESET;
            clr_cnt_reg    <= '0;
            lk_reg         <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
            m_valid        <= 1'b0;
            cur_slot_reg   <= '0;
            msg_left_reg   <= '0;
            chunk_left_reg <= '0;
            cur_ext_reg    <= 1'b0;
            cur_extv_reg   <= '0;
        end else begin
            if (cfg_we && cfg_data != 24'd0) begin
                chunk_max_reg <= cfg_data;
            end
            if (clearing) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            lk_reg  <= take && s_data.command == CMD_HEADER;
            cnt_reg <= cnt_next;
            if (mem_we && !clearing) begin
                fwd_valid_reg <= 1'b1;
            end
            if (out_free) begin
                m_valid <= cnt_reg != '0;
            end
            if (lk_reg) begin
                cur_slot_reg   <= hdr_reg.csid;
                msg_left_reg   <= hdr_reg.msg_len;
                chunk_left_reg <= chunk_max_reg;
                cur_ext_reg    <= ext;
                cur_extv_reg   <= extv;
            end else if (take && s_data.command == CMD_PAYLOAD && msg_left_reg != 24'd0) begin
                msg_left_reg <= msg_left_reg - 24'd1;
                chunk_left_reg <= ((chunk_left_reg == 24'd0) ? chunk_max_reg
                                   : chunk_left_reg) - 24'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
        if (take) begin
            hdr_reg <= s_data;
        end
        if (lk_reg) begin
            fwd_entry_reg <= new_entry;
            fwd_addr_reg  <= hdr_reg.csid[SLOT_W-1:0];
        end
        if (out_free && cnt_reg != '0) begin
            m_data.out_byte    <= buf_reg[BUF_BYTES*8-1 -: 8];
            m_data.last_of_run <= cnt_reg == 5'd1;
        end
    end

endmodule

FILE: hdl/rce_checker.sv
// port-level checker for the chunk encoder, bound to the top level
`include "rtmp_chunk_encoder_macros.svh"
module rce_checker
    import rce_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input rce_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input rce_out_t m_data
);
    `RCE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `RCE_ASSERT_NEXT(a_hdr_busy, aclk, aresetn, s_valid && s_ready && s_data.command == CMD_HEADER, !s_ready)
    `RCE_ASSERT_IMPL(a_busy_out, aclk, aresetn, m_valid && !m_ready, !s_ready)
endmodule

bind rtmp_chunk_encoder rce_checker u_rce_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_data (s_data),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

FILE: verif/tb_rtmp_chunk_encoder.sv
// testbench for rtmp_chunk_encoder: predicts the bytes of each item and checks them
`timescale 1ns / 1ps

module tb_rtmp_chunk_encoder;
    import rce_pkg::*;

    localparam int WATCHDOG_LIMIT = 4 * STREAM_SLOTS + 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    rce_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    rce_out_t    m_data;
    logic        cfg_we;
    logic [23:0] cfg_data;

    rtmp_chunk_encoder i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data)
    );

    // encoder state mirror
    logic [23:0] chunk_max_q;
    logic        tbl_valid [STREAM_SLOTS];
    logic [31:0] tbl_ts [STREAM_SLOTS];
    logic [31:0] tbl_delta [STREAM_SLOTS];
    logic [23:0] tbl_len [STREAM_SLOTS];
    logic [7:0]  tbl_type [STREAM_SLOTS];
    logic [31:0] tbl_stream [STREAM_SLOTS];
    logic        tbl_ext [STREAM_SLOTS];
    logic [31:0] tbl_extv [STREAM_SLOTS];
    logic [9:0]  open_csid;
    logic [23:0] msg_left;
    logic [23:0] chunk_left;
    logic        open_ext;
    logic [31:0] open_extv;

    rce_out_t    byte_queue[$];
    int          errors;
    int          idle_cycles;
    bit          rx_hold;
    logic [31:0] last_ts [1024];

    initial begin
        aclk = 1'b0;
    end

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic push_byte(input logic [7:0] b);
        rce_out_t e;
        e.out_byte = b;
        e.last_of_run = 1'b0;
        byte_queue = {byte_queue, e};
    endtask

    task automatic push_basic(input logic [1:0] fmt, input logic [9:0] csid);
        logic [9:0] r;
        r = csid - 10'd64;
        if (csid < 10'd64) begin
            push_byte({fmt, csid[5:0]});
        end else if (csid < 10'd320) begin
            push_byte({fmt, 6'd0});
            push_byte(r[7:0]);
        end else begin
            push_byte({fmt, 6'd1});
            push_byte(r[7:0]);
            push_byte({6'd0, r[9:8]});
        end
    endtask

    task automatic push32(input logic [31:0] v);
        push_byte(v[31:24]);
        push_byte(v[23:16]);
        push_byte(v[15:8]);
        push_byte(v[7:0]);
    endtask

    task automatic predict_encoding(input rce_in_t it);
        int          n0;
        int          s;
        logic [1:0]  fmt;
        logic [31:0] delta;
        logic [31:0] extv;
        logic        ext;
        logic [23:0] tsf;
        n0 = byte_queue.size();
        s = it.csid % STREAM_SLOTS;
        delta = '0;
        if (it.command == CMD_HEADER) begin
            if (!tbl_valid[s] || it.msg_stream != tbl_stream[s]
                    || it.timestamp < tbl_ts[s]) begin
                fmt = 2'd0;
            end else begin
                delta = it.timestamp - tbl_ts[s];
                if (it.msg_len != tbl_len[s] || it.msg_type != tbl_type[s])
                    fmt = 2'd1;
                else if (delta != tbl_delta[s])
                    fmt = 2'd2;
                else
                    fmt = 2'd3;
            end
            if (fmt == 2'd0) begin
                ext = it.timestamp >= {8'd0, EXT_MARK};
                extv = it.timestamp;
            end else if (fmt != 2'd3) begin
                ext = delta >= {8'd0, EXT_MARK};
                extv = delta;
            end else begin
                ext = tbl_ext[s];
                extv = tbl_extv[s];
            end
            tsf = ext ? EXT_MARK : extv[23:0];
            push_basic(fmt, it.csid);
            if (fmt != 2'd3) begin
                push_byte(tsf[23:16]);
                push_byte(tsf[15:8]);
                push_byte(tsf[7:0]);
            end
            if (fmt <= 2'd1) begin
                push_byte(it.msg_len[23:16]);
                push_byte(it.msg_len[15:8]);
                push_byte(it.msg_len[7:0]);
                push_byte(it.msg_type);
            end
            if (fmt == 2'd0) begin
                push_byte(it.msg_stream[7:0]);
                push_byte(it.msg_stream[15:8]);
                push_byte(it.msg_stream[23:16]);
                push_byte(it.msg_stream[31:24]);
            end
            if (ext)
                push32(extv);
            tbl_valid[s] = 1'b1;
            tbl_ts[s] = it.timestamp;
            tbl_delta[s] = (fmt == 2'd0) ? 32'd0 : delta;
            tbl_len[s] = it.msg_len;
            tbl_type[s] = it.msg_type;
            tbl_stream[s] = it.msg_stream;
            tbl_ext[s] = ext;
            tbl_extv[s] = extv;
            open_csid = it.csid;
            msg_left = it.msg_len;
            chunk_left = chunk_max_q;
            open_ext = ext;
            open_extv = extv;
        end else if (msg_left != 24'd0) begin
            if (chunk_left == 24'd0) begin
                push_basic(2'd3, open_csid);
                if (open_ext)
                    push32(open_extv);
                chunk_left = chunk_max_q;
            end
            push_byte(it.payload_byte);
            msg_left--;
            chunk_left--;
        end
        if (byte_queue.size() > n0)
            byte_queue[byte_queue.size() - 1].last_of_run = 1'b1;
    endtask

    task automatic send_item(input rce_in_t it);
        int gap;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do
            @(posedge aclk);
        while (!s_ready);
        predict_encoding(it);
        @(negedge aclk);
    endtask

    task automatic write_chunk_max(input logic [23:0] v);
        s_valid <= 1'b0;
        while (byte_queue.size() != 0)
            @(negedge aclk);
        repeat (30) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (v != 24'd0)
            chunk_max_q = v;
    endtask

    function automatic rce_in_t rand_header(input logic [9:0] csid);
        rce_in_t it;
        it.command = CMD_HEADER;
        it.csid = csid;
        it.msg_stream = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2);
        it.msg_type = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'd9;
        it.timestamp = $urandom;
        it.msg_len = 24'($urandom_range(0, 12));
        it.payload_byte = 8'($urandom);
        return it;
    endfunction

    function automatic rce_in_t payload(input logic [7:0] b);
        rce_in_t it;
        it = '0;
        it.command = CMD_PAYLOAD;
        it.csid = 10'($urandom);
        it.msg_stream = $urandom;
        it.timestamp = $urandom;
        it.msg_len = 24'($urandom);
        it.msg_type = 8'($urandom);
        it.payload_byte = b;
        return it;
    endfunction

    function automatic logic [9:0] rand_csid();
        case ($urandom_range(0, 3))
            0: return 10'($urandom_range(2, 63));
            1: return 10'($urandom_range(64, 319));
            2: return 10'($urandom_range(320, 1023));
            default: return 10'($urandom_range(2, 6));
        endcase
    endfunction

    task automatic send_message(input rce_in_t h);
        send_item(h);
        for (int i = 0; i < h.msg_len; i++)
            send_item(payload(8'($urandom)));
    endtask

    task automatic test_formats();
        rce_in_t h;
        h = '0;
        h.csid = 10'd2;
        h.msg_stream = 32'h01020304;
        h.msg_type = 8'h12;
        h.timestamp = 32'd1000;
        h.msg_len = 24'd2;
        send_message(h);
        h.timestamp = 32'd1040;
        h.msg_len = 24'd3;
        send_message(h);
        h.timestamp = 32'd1080;
        send_message(h);
        h.timestamp = 32'd1100;
        send_message(h);
        h.timestamp = 32'd1120;
        send_message(h);
        h.timestamp = 32'd10;
        send_message(h);
        // extended timestamp and long ids
        h.csid = 10'd1023;
        h.msg_stream = 32'hFFFFFFFF;
        h.msg_type = 8'hFF;
        h.timestamp = 32'hFFFFFFFF;
        h.msg_len = 24'd1;
        send_message(h);
        h.timestamp = 32'hFFFFFFFF;
        send_message(h);
        h.csid = 10'd64;
        h.timestamp = 32'h00FFFFFF;
        h.msg_len = 24'hFFFFFF;
        send_item(h);
        h.csid = 10'd319;
        h.timestamp = 32'h0;
        h.msg_stream = 32'h0;
        h.msg_type = 8'h0;
        h.msg_len = 24'd0;
        send_item(h);
        send_item(payload(8'hAA));
        h.csid = 10'd320;
        h.timestamp = 32'h5;
        send_item(h);
        h.csid = 10'd0;
        send_item(h);
        h.csid = 10'd1;
        h.msg_len = 24'd1;
        send_item(h);
        send_item(payload(8'hFF));
        send_item(payload(8'h00));
    endtask

    task automatic test_chunking();
        rce_in_t h;
        write_chunk_max(24'd0);
        write_chunk_max(24'd1);
        h = rand_header(10'd700);
        h.timestamp = 32'hFFFFFFF0;
        h.msg_len = 24'd5;
        send_message(h);
        write_chunk_max(24'd3);
        h = rand_header(10'd40);
        h.msg_len = 24'd4;
        send_item(h);
        send_item(payload(8'h11));
        write_chunk_max(24'd2);
        for (int i = 0; i < 3; i++)
            send_item(payload(8'($urandom)));
        write_chunk_max(24'hFFFFFF);
        send_message(rand_header(10'd41));
    endtask

    task automatic test_random_messages(input int n_items);
        int sent;
        rce_in_t h;
        logic [9:0] c;
        sent = 0;
        while (sent < n_items) begin
            c = rand_csid();
            h = rand_header(c);
            if ($urandom_range(0, 2) != 0 && last_ts[c] < 32'hFFFF0000)
                h.timestamp = last_ts[c] + $urandom_range(0, 2) * 20;
            last_ts[c] = h.timestamp;
            if ($urandom_range(0, 4) == 0) begin
                send_item(h);
                send_item(payload(8'($urandom)));
                sent += 2;
            end else begin
                send_message(h);
                sent += 1 + h.msg_len;
            end
            if ($urandom_range(0, 9) == 0) begin
                send_item(payload(8'($urandom)));
                sent++;
            end
            if ($urandom_range(0, 30) == 0)
                write_chunk_max(24'($urandom_range(1, 6)));
        end
    endtask

    task automatic test_backpressure();
        rce_in_t h;
        rx_hold = 1'b1;
        h = rand_header(10'd900);
        h.msg_len = 24'd20;
        send_message(h);
        rx_hold = 1'b0;
    endtask

    always @(negedge aclk) begin
        int stall;
        if (rx_hold) begin
            m_ready <= 1'b0;
            repeat (200) @(negedge aclk);
            m_ready <= 1'b1;
            wait (!rx_hold);
        end else if ($urandom_range(0, 3) == 0) begin
            stall = $urandom_range(0, 15);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        rce_out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (byte_queue.size() == 0) begin
                errors++;
                $display("%0t unexpected byte: expected none actual %h/%b",
                    $realtime, m_data.out_byte, m_data.last_of_run);
            end else begin
                e = byte_queue.pop_front();
                if (m_data.out_byte !== e.out_byte) begin
                    errors++;
                    $display("%0t out_byte: expected %h actual %h",
                        $realtime, e.out_byte, m_data.out_byte);
                end
                if (m_data.last_of_run !== e.last_of_run) begin
                    errors++;
                    $display("%0t last_of_run: expected %b actual %b",
                        $realtime, e.last_of_run, m_data.last_of_run);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int drain;
        errors = 0;
        idle_cycles = 0;
        rx_hold = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        chunk_max_q = CHUNK_MAX_RESET;
        msg_left = '0;
        chunk_left = '0;
        open_csid = '0;
        open_ext = 1'b0;
        open_extv = '0;
        for (int i = 0; i < STREAM_SLOTS; i++)
            tbl_valid[i] = 1'b0;
        for (int i = 0; i < 1024; i++)
            last_ts[i] = '0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        test_formats();
        test_chunking();
        test_backpressure();
        write_chunk_max(24'd4);
        test_random_messages(200);
        write_chunk_max(CHUNK_MAX_RESET);
        test_random_messages(40);
        s_valid <= 1'b0;
        drain = 0;
        while (byte_queue.size() != 0 && drain < 100000) begin
            @(negedge aclk);
            drain++;
        end
        repeat (40) @(negedge aclk);
        if (errors == 0 && byte_queue.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/rce_pkg.sv
hdl/rce_ram.sv
hdl/rtmp_chunk_encoder.sv
hdl/rce_checker.sv
verif/tb_rtmp_chunk_encoder.sv
